[rtl/vpdf_pkg.sv]
package vpdf_pkg;

    // field and register widths
    localparam int PosW    = 32;
    localparam int CoefW   = 16;
    localparam int ColW    = 8;
    localparam int CfgW    = 64;
    localparam int CfgIdxW = 3;
    localparam int FadeW   = 32;
    localparam int OutW    = 32;

    // datapath widths
    localparam int ProdW   = CoefW + PosW;        // one coefficient times one coordinate
    localparam int LaneW   = ProdW + 4;           // transformed lane, Q.28
    localparam int DivInW  = LaneW + 1;           // numerator / denominator at divider input
    localparam int DivNumW = DivInW + 4;          // numerator magnitude scaled by 16
    localparam int DivDenW = DivInW;              // denominator magnitude
    localparam int QuoW    = OutW + 1;            // quotient bits before saturation
    localparam int DivLat  = QuoW + 3;            // prep, range check, steps, saturation
    localparam int DepthSt = 4;                   // depth and colour stages before the delay line
    localparam int DelayLen = DivLat - DepthSt;
    localparam int FrontSt = 3;                   // products, sums, divider operands
    localparam int TotLat  = FrontSt + DivLat;

    // register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_ROW_X = 3'd0,
        REG_ROW_Y = 3'd1,
        REG_ROW_Z = 3'd2,
        REG_ROW_T = 3'd3,
        REG_CEIL  = 3'd4,
        REG_BIAS  = 3'd5,
        REG_SLOPE = 3'd6
    } cfg_reg_t;

    // reset values
    localparam logic [CfgW-1:0] ROW_X_RST = 64'h0000_0000_0000_1000;
    localparam logic [CfgW-1:0] ROW_Y_RST = 64'h0000_0000_1000_0000;
    localparam logic [CfgW-1:0] ROW_Z_RST = 64'h0000_1000_0000_0000;
    localparam logic [CfgW-1:0] ROW_T_RST = 64'h1000_0000_0000_0000;
    localparam logic [FadeW-1:0] CEIL_RST  = 32'h00FF_0000;
    localparam logic [FadeW-1:0] BIAS_RST  = 32'h0000_0000;
    localparam logic [FadeW-1:0] SLOPE_RST = 32'h0001_0000;

    // fade modes and the constant fade word
    localparam logic [1:0] MODE_NONE    = 2'd0;
    localparam logic [1:0] MODE_ALPHA   = 2'd1;
    localparam logic [1:0] MODE_RGB     = 2'd2;
    localparam logic [1:0] MODE_RGB_ALT = 2'd3;
    localparam logic [OutW-1:0] FADE_DONE = 32'h0000_0FF0;

    localparam logic [OutW-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [OutW-1:0] SAT_MIN = 32'h8000_0000;

    // colour and mode carried alongside the datapath
    typedef struct packed {
        logic [ColW-1:0] red;
        logic [ColW-1:0] green;
        logic [ColW-1:0] blue;
        logic [ColW-1:0] alpha;
        logic [1:0]      mode;
    } col_t;

    // finished fade word and colour
    typedef struct packed {
        logic [OutW-1:0] fade_word;
        logic [ColW-1:0] red;
        logic [ColW-1:0] green;
        logic [ColW-1:0] blue;
        logic [ColW-1:0] alpha;
    } side_t;

endpackage

[rtl/vpdf_in_if.sv]
interface vpdf_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [vpdf_pkg::PosW-1:0]  pos_x;
    logic signed [vpdf_pkg::PosW-1:0]  pos_y;
    logic signed [vpdf_pkg::PosW-1:0]  pos_z;
    logic [vpdf_pkg::ColW-1:0]         color_red;
    logic [vpdf_pkg::ColW-1:0]         color_green;
    logic [vpdf_pkg::ColW-1:0]         color_blue;
    logic [vpdf_pkg::ColW-1:0]         color_alpha;
    logic [1:0]                        fade_mode;

    modport source (
        output valid, pos_x, pos_y, pos_z, color_red, color_green, color_blue,
               color_alpha, fade_mode,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, color_red, color_green, color_blue,
               color_alpha, fade_mode,
        output ready
    );
endinterface

[rtl/vpdf_out_if.sv]
interface vpdf_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [vpdf_pkg::OutW-1:0]  screen_x;
    logic signed [vpdf_pkg::OutW-1:0]  screen_y;
    logic signed [vpdf_pkg::OutW-1:0]  screen_z;
    logic signed [vpdf_pkg::OutW-1:0]  fade_word;
    logic [vpdf_pkg::ColW-1:0]         out_red;
    logic [vpdf_pkg::ColW-1:0]         out_green;
    logic [vpdf_pkg::ColW-1:0]         out_blue;
    logic [vpdf_pkg::ColW-1:0]         out_alpha;

    modport source (
        output valid, screen_x, screen_y, screen_z, fade_word, out_red, out_green,
               out_blue, out_alpha,
        input  ready
    );
    modport sink (
        input  valid, screen_x, screen_y, screen_z, fade_word, out_red, out_green,
               out_blue, out_alpha,
        output ready
    );
endinterface

[rtl/vpdf_div.sv]
// Pipelined restoring divider: quo = sat32(trunc(16 * num / den)),
// zero divisor saturates by the sign of num. One quotient bit per stage.
module vpdf_div (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [vpdf_pkg::DivInW-1:0]    num,
    input  logic signed [vpdf_pkg::DivInW-1:0]    den,
    output logic signed [vpdf_pkg::OutW-1:0]      quo
);

    localparam int NW = vpdf_pkg::DivNumW;
    localparam int DW = vpdf_pkg::DivDenW;
    localparam int QW = vpdf_pkg::QuoW;
    localparam int CW = DW + QW;

    typedef struct packed {
        logic [NW-1:0] r;
        logic [DW-1:0] d;
        logic [QW-1:0] q;
        logic          ovf;
        logic          sat_neg;
        logic          neg;
    } step_t;

    logic [DW-1:0] num_mag;
    logic [DW-1:0] den_mag;
    logic [NW-1:0] a_n_reg;
    logic [DW-1:0] a_d_reg;
    logic          a_num_neg_reg;
    logic          a_den_neg_reg;
    logic          a_dz_reg;
    step_t         st_reg  [0:QW];
    step_t         st_next [1:QW];
    logic [CW-1:0] rem_w;
    logic [CW-1:0] sub_w;
    step_t         fin;

    assign num_mag = num[DW-1] ? DW'(-num) : DW'(num);
    assign den_mag = den[DW-1] ? DW'(-den) : DW'(den);

    // operand magnitudes, numerator scaled by 16 to 53.4
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_n_reg       <= {num_mag, 4'b0000};
            a_d_reg       <= den_mag;
            a_num_neg_reg <= num[DW-1];
            a_den_neg_reg <= den[DW-1];
            a_dz_reg      <= (den_mag == '0);
        end
    end

    // one trial subtract per stage, most significant bit first
    always_comb
    begin
        rem_w = '0;
        sub_w = '0;
        for (int g = 1; g <= QW; g++)
        begin
            st_next[g] = st_reg[g-1];
            rem_w = CW'(st_reg[g-1].r);
            sub_w = CW'(st_reg[g-1].d) << (QW - g);
            if (rem_w >= sub_w)
            begin
                st_next[g].r        = NW'(rem_w - sub_w);
                st_next[g].q[QW-g]  = 1'b1;
            end
        end
    end

    // range check into stage 0 (quotient too large, or zero divisor), then the steps
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0].r       <= a_n_reg;
            st_reg[0].d       <= a_d_reg;
            st_reg[0].q       <= '0;
            st_reg[0].ovf     <= (CW'(a_n_reg) >= {a_d_reg, {QW{1'b0}}});
            st_reg[0].sat_neg <= a_dz_reg ? a_num_neg_reg : (a_num_neg_reg ^ a_den_neg_reg);
            st_reg[0].neg     <= a_num_neg_reg ^ a_den_neg_reg;
            for (int g = 1; g <= QW; g++)
            begin
                st_reg[g] <= st_next[g];
            end
        end
    end

    // sign and saturation
    assign fin = st_reg[QW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (fin.ovf)
            begin
                quo <= fin.sat_neg ? vpdf_pkg::SAT_MIN : vpdf_pkg::SAT_MAX;
            end
            else if (fin.neg)
            begin
                quo <= (fin.q > {1'b0, vpdf_pkg::SAT_MIN}) ? vpdf_pkg::SAT_MIN
                                                            : vpdf_pkg::OutW'(-fin.q);
            end
            else
            begin
                quo <= (fin.q > {1'b0, vpdf_pkg::SAT_MAX}) ? vpdf_pkg::SAT_MAX
                                                            : fin.q[vpdf_pkg::OutW-1:0];
            end
        end
    end

endmodule

[rtl/vertex_project_depth_fade_core.sv]
// Vertex projection with depth fade.
// Throughput: one vertex per cycle; the pipeline advances whenever its last
// stage is empty or the output beat is taken, so a stall holds every stage.
// The restoring dividers, with 33 step stages each, set the depth of the pipeline.
// Reset clears all valid bits and loads the configuration registers.
module vertex_project_depth_fade_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [vpdf_pkg::CfgIdxW-1:0]      cfg_idx,
    input  logic [vpdf_pkg::CfgW-1:0]         cfg_data,
    vpdf_in_if.sink                           vtx_in,
    vpdf_out_if.source                        vtx_out
);

    localparam int LastSt = vpdf_pkg::TotLat - 1;
    localparam int LaneW  = vpdf_pkg::LaneW;
    localparam int ProdW  = vpdf_pkg::ProdW;
    localparam int DivInW = vpdf_pkg::DivInW;
    localparam int DlyLen = vpdf_pkg::DelayLen;

    // configuration registers
    logic [vpdf_pkg::CfgW-1:0]          row_x_reg;
    logic [vpdf_pkg::CfgW-1:0]          row_y_reg;
    logic [vpdf_pkg::CfgW-1:0]          row_z_reg;
    logic [vpdf_pkg::CfgW-1:0]          row_t_reg;
    logic signed [vpdf_pkg::FadeW-1:0]  ceil_reg;
    logic signed [vpdf_pkg::FadeW-1:0]  bias_reg;
    logic signed [vpdf_pkg::FadeW-1:0]  slope_reg;

    logic                               en;
    logic                               valid_reg [0:LastSt];

    logic signed [ProdW-1:0]            prod_reg [0:3][0:2];
    vpdf_pkg::col_t                     s1_col_reg;
    logic signed [LaneW-1:0]            v_reg [0:3];
    vpdf_pkg::col_t                     s2_col_reg;
    logic signed [DivInW-1:0]           num_x_reg;
    logic signed [DivInW-1:0]           num_y_reg;
    logic signed [DivInW-1:0]           num_z_reg;
    logic signed [DivInW-1:0]           den_w_reg;
    logic signed [DivInW-1:0]           den_z_reg;
    vpdf_pkg::col_t                     s3_col_reg;

    // depth path
    logic signed [58:0]                 d4_hi_reg;
    logic signed [58:0]                 d4_lo_reg;
    vpdf_pkg::col_t                     d4_col_reg;
    logic signed [84:0]                 d5_p;
    logic signed [56:0]                 d5_q_reg;
    logic                               d5_frac_reg;
    vpdf_pkg::col_t                     d5_col_reg;
    logic signed [57:0]                 d6_d_reg;
    logic                               d6_frac_reg;
    vpdf_pkg::col_t                     d6_col_reg;
    logic signed [57:0]                 d7_ceil;
    logic signed [57:0]                 d7_hi;
    logic signed [57:0]                 d7_cl;
    logic [18:0]                        d7_fade_reg;
    logic [vpdf_pkg::ColW-1:0]          d7_f_reg;
    vpdf_pkg::col_t                     d7_col_reg;
    logic [2*vpdf_pkg::ColW-1:0]        d8_r;
    logic [2*vpdf_pkg::ColW-1:0]        d8_g;
    logic [2*vpdf_pkg::ColW-1:0]        d8_b;
    logic [2*vpdf_pkg::ColW-1:0]        d8_a;
    vpdf_pkg::side_t                    d8_side;
    vpdf_pkg::side_t                    side_reg [0:DlyLen-1];

    logic signed [vpdf_pkg::OutW-1:0]   sx;
    logic signed [vpdf_pkg::OutW-1:0]   sy;
    logic signed [vpdf_pkg::OutW-1:0]   sz;

    // global advance
    assign en           = !valid_reg[LastSt] || vtx_out.ready;
    assign vtx_in.ready = en;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_reg <= vpdf_pkg::ROW_X_RST;
            row_y_reg <= vpdf_pkg::ROW_Y_RST;
            row_z_reg <= vpdf_pkg::ROW_Z_RST;
            row_t_reg <= vpdf_pkg::ROW_T_RST;
            ceil_reg  <= vpdf_pkg::CEIL_RST;
            bias_reg  <= vpdf_pkg::BIAS_RST;
            slope_reg <= vpdf_pkg::SLOPE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                vpdf_pkg::REG_ROW_X: row_x_reg <= cfg_data;
                vpdf_pkg::REG_ROW_Y: row_y_reg <= cfg_data;
                vpdf_pkg::REG_ROW_Z: row_z_reg <= cfg_data;
                vpdf_pkg::REG_ROW_T: row_t_reg <= cfg_data;
                vpdf_pkg::REG_CEIL:  ceil_reg  <= cfg_data[vpdf_pkg::FadeW-1:0];
                vpdf_pkg::REG_BIAS:  bias_reg  <= cfg_data[vpdf_pkg::FadeW-1:0];
                vpdf_pkg::REG_SLOPE: slope_reg <= cfg_data[vpdf_pkg::FadeW-1:0];
                default: ;
            endcase
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LastSt; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= vtx_in.valid;
            for (int i = 1; i <= LastSt; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // stage 1 products and stage 2 lane sums, one lane each
    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                prod_reg[g][0] <= $signed(row_x_reg[16*g +: 16]) * vtx_in.pos_x;
                prod_reg[g][1] <= $signed(row_y_reg[16*g +: 16]) * vtx_in.pos_y;
                prod_reg[g][2] <= $signed(row_z_reg[16*g +: 16]) * vtx_in.pos_z;
                v_reg[g] <= LaneW'(prod_reg[g][0]) + LaneW'(prod_reg[g][1])
                          + LaneW'(prod_reg[g][2])
                          + (LaneW'($signed(row_t_reg[16*g +: 16])) <<< 16);
            end
        end
    end

    // stage 3 divider operands; biased w divides z
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_col_reg <= '{red: vtx_in.color_red, green: vtx_in.color_green,
                            blue: vtx_in.color_blue, alpha: vtx_in.color_alpha,
                            mode: vtx_in.fade_mode};
            s2_col_reg <= s1_col_reg;
            s3_col_reg <= s2_col_reg;
            num_x_reg  <= DivInW'(v_reg[0]);
            num_y_reg  <= DivInW'(v_reg[1]);
            num_z_reg  <= DivInW'(v_reg[2]);
            den_w_reg  <= DivInW'(v_reg[3]);
            den_z_reg  <= DivInW'(v_reg[3]) - (DivInW'(1) <<< 28);
        end
    end

    vpdf_div u_div_x (.clk(clk), .en(en), .num(num_x_reg), .den(den_w_reg), .quo(sx));
    vpdf_div u_div_y (.clk(clk), .en(en), .num(num_y_reg), .den(den_w_reg), .quo(sy));
    vpdf_div u_div_z (.clk(clk), .en(en), .num(num_z_reg), .den(den_z_reg), .quo(sz));

    // depth: slope * wb split into two 32x27 products, floor(>>28), bias, clamp
    assign d5_p    = (85'(d4_hi_reg) <<< 26) + 85'(d4_lo_reg);
    assign d7_ceil = 58'(ceil_reg);
    assign d7_hi   = ((d6_d_reg > d7_ceil) || ((d6_d_reg == d7_ceil) && d6_frac_reg))
                     ? d7_ceil : d6_d_reg;
    assign d7_cl   = (d7_hi < 0) ? '0 : d7_hi;

    // colour scaling by the integer factor
    assign d8_r = d7_col_reg.red   * d7_f_reg;
    assign d8_g = d7_col_reg.green * d7_f_reg;
    assign d8_b = d7_col_reg.blue  * d7_f_reg;
    assign d8_a = d7_col_reg.alpha * d7_f_reg;

    always_comb
    begin
        d8_side.fade_word = vpdf_pkg::FADE_DONE;
        d8_side.red       = d7_col_reg.red;
        d8_side.green     = d7_col_reg.green;
        d8_side.blue      = d7_col_reg.blue;
        d8_side.alpha     = d7_col_reg.alpha;
        if (d7_col_reg.mode == vpdf_pkg::MODE_NONE)
        begin
            d8_side.fade_word = vpdf_pkg::OutW'(d7_fade_reg);
        end
        else if (d7_col_reg.mode == vpdf_pkg::MODE_ALPHA)
        begin
            d8_side.alpha = d8_a[15:8];
        end
        else
        begin
            d8_side.red   = d8_r[15:8];
            d8_side.green = d8_g[15:8];
            d8_side.blue  = d8_b[15:8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d4_hi_reg   <= slope_reg * $signed(den_z_reg[52:26]);
            d4_lo_reg   <= slope_reg * $signed({1'b0, den_z_reg[25:0]});
            d4_col_reg  <= s3_col_reg;
            d5_q_reg    <= d5_p[84:28];
            d5_frac_reg <= |d5_p[27:0];
            d5_col_reg  <= d4_col_reg;
            d6_d_reg    <= 58'(bias_reg) + 58'(d5_q_reg);
            d6_frac_reg <= d5_frac_reg;
            d6_col_reg  <= d5_col_reg;
            d7_fade_reg <= d7_cl[30:12];
            d7_f_reg    <= (|d7_cl[30:24]) ? 8'hFF : d7_cl[23:16];
            d7_col_reg  <= d6_col_reg;
            side_reg[0] <= d8_side;
            for (int i = 1; i < DlyLen; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // output beat
    assign vtx_out.valid     = valid_reg[LastSt];
    assign vtx_out.screen_x  = sx;
    assign vtx_out.screen_y  = sy;
    assign vtx_out.screen_z  = sz;
    assign vtx_out.fade_word = side_reg[DlyLen-1].fade_word;
    assign vtx_out.out_red   = side_reg[DlyLen-1].red;
    assign vtx_out.out_green = side_reg[DlyLen-1].green;
    assign vtx_out.out_blue  = side_reg[DlyLen-1].blue;
    assign vtx_out.out_alpha = side_reg[DlyLen-1].alpha;

endmodule
